/* rtl/core/acce_pkg.sv */
// shared types, byte codes and sizes for the console cursor engine
package acce_pkg;

    // escape parameter slots counted by the parser; only the first two are stored
    localparam int PARAM_SLOTS = 4;
    localparam int CNT_W       = $clog2(PARAM_SLOTS + 1);

    // command queue between parser and cursor engine
    localparam int CMD_DEPTH = 4;
    localparam int PTR_W     = $clog2(CMD_DEPTH);
    localparam int FILL_W    = $clog2(CMD_DEPTH + 1);

    // register reset values
    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;

    // register indexes
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // byte codes
    localparam logic [7:0] CODE_ESC   = 8'h1B;
    localparam logic [7:0] CODE_LBRK  = 8'h5B;
    localparam logic [7:0] CODE_SEMI  = 8'h3B;
    localparam logic [7:0] CODE_H     = 8'h48;
    localparam logic [7:0] CODE_F     = 8'h66;
    localparam logic [7:0] CODE_J     = 8'h4A;
    localparam logic [7:0] CODE_LF    = 8'h0A;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] CODE_BS    = 8'h08;
    localparam logic [7:0] CODE_SPACE = 8'h20;
    localparam logic [7:0] CODE_ZERO  = 8'h30;
    localparam logic [7:0] CODE_NINE  = 8'h39;

    localparam logic [7:0] PARAM_MAX = 8'd255;

    // erase modes that clear the screen
    localparam logic [7:0] ERASE_BELOW = 8'd0;
    localparam logic [7:0] ERASE_ALL   = 8'd2;

    // result kinds
    localparam logic ACT_DRAW  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // cursor commands
    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_SETPOS,
        OP_CLEAR
    } op_t;

    // one command: glyph in arg0, or row in arg0 and column in arg1
    typedef struct packed {
        op_t        op;
        logic [7:0] arg0;
        logic [7:0] arg1;
    } cmd_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* rtl/core/ansi_csi_console_cursor_engine_unit.sv */
// top level of the console cursor engine: config registers, parser, queue, cursor
//
// Takes one console byte per beat on the s_ side and gives draw-cell and
// clear-screen results on the m_ side. A byte is accepted in any cycle in
// which the four-entry command queue has room, so with the output side
// taking results the block sustains one byte per cycle. The parser turns
// bytes into cursor commands in the cycle they are accepted; the cursor
// engine runs one command per cycle while the output takes its results,
// into a single output register, except that a printable byte that leaves
// the cursor on the bottom row gives its draw beat and then a clear beat.
// A result passes through the command queue and then the output register
// on its way to m_. m_tlast marks the final result of a byte. Screen
// size writes on the cfg_ port take effect at once and are meant for idle
// periods.
module ansi_csi_console_cursor_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // glyph, cell_column, cell_row
    output logic        m_tuser,   // action
    output logic        m_tlast
);

    logic [7:0]           screen_cols_reg;
    logic [7:0]           screen_rows_reg;
    logic                 byte_take;
    logic                 cmd_push;
    logic                 cmd_pop;
    acce_pkg::cmd_t       push_cmd;
    acce_pkg::cmd_t       head_cmd;
    acce_pkg::q_status_t  q_status;
    logic [7:0]           res_glyph;
    logic [7:0]           res_col;
    logic [7:0]           res_row;

    // screen size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_cols_reg <= acce_pkg::COLS_RESET;
            screen_rows_reg <= acce_pkg::ROWS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == acce_pkg::REG_COLS)
                screen_cols_reg <= cfg_data;
            else
                screen_rows_reg <= cfg_data;
        end
    end

    assign s_tready  = !q_status.full;
    assign byte_take = s_tvalid && s_tready;

    // front: parser
    acce_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_take  (byte_take),
        .byte_value (s_tdata),
        .cmd_push   (cmd_push),
        .cmd        (push_cmd)
    );

    // command queue
    acce_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .pop      (cmd_pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // back: cursor engine
    acce_cursor u_cursor (
        .clk         (clk),
        .rst_n       (rst_n),
        .screen_cols (screen_cols_reg),
        .screen_rows (screen_rows_reg),
        .head_cmd    (head_cmd),
        .status      (q_status),
        .pop         (cmd_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_action  (m_tuser),
        .out_glyph   (res_glyph),
        .out_col     (res_col),
        .out_row     (res_row),
        .out_last    (m_tlast)
    );

    assign m_tdata = {res_row, res_col, res_glyph};

endmodule

/* rtl/core/acce_parser.sv */
// front end: escape sequence parser that turns bytes into cursor commands
module acce_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_take,
    input  logic [7:0]        byte_value,
    output logic              cmd_push,
    output acce_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_NORMAL,
        ST_ESCAPE,
        ST_CSI
    } pstate_t;

    pstate_t                     state_reg, state_next;
    logic [7:0]                  p0_reg, p0_next;
    logic [7:0]                  p1_reg, p1_next;
    logic [acce_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]                  acc_reg, acc_next;
    logic                        seen_reg, seen_next;

    logic                        is_digit;
    logic [11:0]                 acc_sum;
    logic [7:0]                  acc_sat;
    logic [7:0]                  eff_p0;
    logic [7:0]                  eff_p1;
    logic                        has_cmd;
    acce_pkg::cmd_t              chr_cmd;

    // digit accumulation, saturating
    always_comb
    begin
        is_digit = byte_value inside {[acce_pkg::CODE_ZERO:acce_pkg::CODE_NINE]};
        acc_sum  = {4'd0, acc_reg} * 12'd10
                 + {4'd0, byte_value - acce_pkg::CODE_ZERO};
        acc_sat  = (acc_sum > {4'd0, acce_pkg::PARAM_MAX}) ? acce_pkg::PARAM_MAX
                                                           : acc_sum[7:0];
    end

    // first two parameters as seen by a final byte, pending value included
    always_comb
    begin
        if (cnt_reg >= acce_pkg::CNT_W'(1))
            eff_p0 = p0_reg;
        else if (seen_reg)
            eff_p0 = acc_reg;
        else
            eff_p0 = 8'd0;
        if (cnt_reg >= acce_pkg::CNT_W'(2))
            eff_p1 = p1_reg;
        else if (seen_reg && (cnt_reg == acce_pkg::CNT_W'(1)))
            eff_p1 = acc_reg;
        else
            eff_p1 = 8'd0;
    end

    // character output command
    always_comb
    begin
        chr_cmd.arg0 = byte_value;
        chr_cmd.arg1 = 8'd0;
        case (byte_value)
            acce_pkg::CODE_LF: chr_cmd.op = acce_pkg::OP_NEWLINE;
            acce_pkg::CODE_CR: chr_cmd.op = acce_pkg::OP_RETURN;
            acce_pkg::CODE_BS: chr_cmd.op = acce_pkg::OP_BACKSPACE;
            default:           chr_cmd.op = acce_pkg::OP_CHAR;
        endcase
    end

    // parser step
    always_comb
    begin
        state_next = state_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        has_cmd    = 1'b0;
        cmd        = chr_cmd;
        case (state_reg)
            ST_NORMAL:
            begin
                if (byte_value == acce_pkg::CODE_ESC)
                    state_next = ST_ESCAPE;
                else
                    has_cmd = 1'b1;
            end
            ST_ESCAPE:
            begin
                p0_next   = 8'd0;
                p1_next   = 8'd0;
                cnt_next  = '0;
                acc_next  = 8'd0;
                seen_next = 1'b0;
                if (byte_value == acce_pkg::CODE_LBRK)
                begin
                    state_next = ST_CSI;
                end
                else
                begin
                    state_next = ST_NORMAL;
                    has_cmd    = 1'b1;
                end
            end
            ST_CSI:
            begin
                if (is_digit)
                begin
                    acc_next  = acc_sat;
                    seen_next = 1'b1;
                end
                else if (byte_value == acce_pkg::CODE_SEMI)
                begin
                    if (cnt_reg < acce_pkg::CNT_W'(acce_pkg::PARAM_SLOTS))
                    begin
                        if (cnt_reg == acce_pkg::CNT_W'(0))
                            p0_next = seen_reg ? acc_reg : 8'd0;
                        else if (cnt_reg == acce_pkg::CNT_W'(1))
                            p1_next = seen_reg ? acc_reg : 8'd0;
                        cnt_next = cnt_reg + acce_pkg::CNT_W'(1);
                    end
                    acc_next  = 8'd0;
                    seen_next = 1'b0;
                end
                else
                begin
                    // final byte ends the sequence
                    state_next = ST_NORMAL;
                    p0_next    = 8'd0;
                    p1_next    = 8'd0;
                    cnt_next   = '0;
                    acc_next   = 8'd0;
                    seen_next  = 1'b0;
                    cmd.arg0   = eff_p0;
                    cmd.arg1   = eff_p1;
                    if ((byte_value == acce_pkg::CODE_H) ||
                        (byte_value == acce_pkg::CODE_F))
                    begin
                        cmd.op  = acce_pkg::OP_SETPOS;
                        has_cmd = 1'b1;
                    end
                    else if (byte_value == acce_pkg::CODE_J)
                    begin
                        cmd.op  = acce_pkg::OP_CLEAR;
                        has_cmd = (eff_p0 == acce_pkg::ERASE_BELOW) ||
                                  (eff_p0 == acce_pkg::ERASE_ALL);
                    end
                end
            end
            default:
            begin
                state_next = ST_NORMAL;
            end
        endcase
    end

    assign cmd_push = byte_take && has_cmd;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_NORMAL;
            p0_reg    <= 8'd0;
            p1_reg    <= 8'd0;
            cnt_reg   <= '0;
            acc_reg   <= 8'd0;
            seen_reg  <= 1'b0;
        end
        else if (byte_take)
        begin
            state_reg <= state_next;
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

/* rtl/core/acce_cmd_fifo.sv */
// short command queue between parser and cursor engine
module acce_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  acce_pkg::cmd_t       push_cmd,
    input  logic                 pop,
    output acce_pkg::cmd_t       head_cmd,
    output acce_pkg::q_status_t  status
);

    acce_pkg::cmd_t                 slot_reg [acce_pkg::CMD_DEPTH];
    logic [acce_pkg::PTR_W-1:0]     wr_ptr_reg;
    logic [acce_pkg::PTR_W-1:0]     rd_ptr_reg;
    logic [acce_pkg::FILL_W-1:0]    fill_reg;

    assign head_cmd     = slot_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == acce_pkg::FILL_W'(acce_pkg::CMD_DEPTH));
    assign status.empty = (fill_reg == '0);

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + acce_pkg::PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + acce_pkg::PTR_W'(1);
            if (push && !pop)
                fill_reg <= fill_reg + acce_pkg::FILL_W'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - acce_pkg::FILL_W'(1);
        end
    end

endmodule

/* rtl/core/acce_cursor.sv */
// back end: cursor engine that runs commands and drives the result register
module acce_cursor (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           screen_cols,
    input  logic [7:0]           screen_rows,
    input  acce_pkg::cmd_t       head_cmd,
    input  acce_pkg::q_status_t  status,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_action,
    output logic [7:0]           out_glyph,
    output logic [7:0]           out_col,
    output logic [7:0]           out_row,
    output logic                 out_last
);

    logic [7:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;
    logic        out_valid_reg;
    logic        pend_clear_reg;
    logic        act_reg;
    logic [7:0]  glyph_reg;
    logic [7:0]  ocol_reg;
    logic [7:0]  orow_reg;
    logic        last_reg;

    logic        slot_free;
    logic        run_cmd;
    logic        emit_pend;
    logic        res_valid;
    logic        res_act;
    logic [7:0]  res_glyph;
    logic [7:0]  res_col;
    logic [7:0]  res_row;
    logic        extra_clear;
    logic [7:0]  adv_col;
    logic [7:0]  adv_row;
    logic [7:0]  pos_row;
    logic [7:0]  pos_col;

    assign slot_free = !out_valid_reg || out_ready;
    assign emit_pend = slot_free && pend_clear_reg;
    assign run_cmd   = slot_free && !pend_clear_reg && !status.empty;
    assign pop       = run_cmd;

    // clamp a cursor position parameter to 1..limit
    function automatic logic [7:0] clamp_pos(input logic [7:0] v, input logic [7:0] lim);
        logic [7:0] t;
        t = (v == 8'd0) ? 8'd1 : v;
        if (t > lim)
            t = lim;
        if (t == 8'd0)
            t = 8'd1;
        return t;
    endfunction

    // work out the results and new cursor for the head command
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        res_valid   = 1'b0;
        res_act     = acce_pkg::ACT_DRAW;
        res_glyph   = head_cmd.arg0;
        res_col     = col_reg;
        res_row     = row_reg;
        extra_clear = 1'b0;
        adv_col     = col_reg + 8'd1;
        adv_row     = row_reg;
        pos_row     = clamp_pos(head_cmd.arg0, screen_rows);
        pos_col     = clamp_pos(head_cmd.arg1, screen_cols);
        case (head_cmd.op)
            acce_pkg::OP_CHAR:
            begin
                res_valid = 1'b1;
                if (({1'b0, adv_col} + 9'd1) >= {1'b0, screen_cols})
                begin
                    adv_col = 8'd0;
                    adv_row = row_reg + 8'd1;
                end
                col_next = adv_col;
                row_next = adv_row;
                if (({1'b0, adv_row} + 9'd1) >= {1'b0, screen_rows})
                begin
                    extra_clear = 1'b1;
                    col_next    = 8'd0;
                    row_next    = 8'd0;
                end
            end
            acce_pkg::OP_NEWLINE:
            begin
                adv_row  = row_reg + 8'd1;
                col_next = 8'd0;
                row_next = adv_row;
                if (({1'b0, adv_row} + 9'd1) >= {1'b0, screen_rows})
                begin
                    res_valid = 1'b1;
                    res_act   = acce_pkg::ACT_CLEAR;
                    res_glyph = 8'd0;
                    res_col   = 8'd0;
                    res_row   = 8'd0;
                    row_next  = 8'd0;
                end
            end
            acce_pkg::OP_RETURN:
            begin
                col_next = 8'd0;
            end
            acce_pkg::OP_BACKSPACE:
            begin
                if (col_reg != 8'd0)
                    col_next = col_reg - 8'd1;
                res_valid = 1'b1;
                res_glyph = acce_pkg::CODE_SPACE;
                res_col   = col_next;
            end
            acce_pkg::OP_SETPOS:
            begin
                row_next = pos_row - 8'd1;
                col_next = pos_col - 8'd1;
            end
            acce_pkg::OP_CLEAR:
            begin
                res_valid = 1'b1;
                res_act   = acce_pkg::ACT_CLEAR;
                res_glyph = 8'd0;
                res_col   = 8'd0;
                res_row   = 8'd0;
                col_next  = 8'd0;
                row_next  = 8'd0;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // cursor and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= 8'd0;
            row_reg        <= 8'd0;
            out_valid_reg  <= 1'b0;
            pend_clear_reg <= 1'b0;
        end
        else
        begin
            if (emit_pend)
            begin
                out_valid_reg  <= 1'b1;
                pend_clear_reg <= 1'b0;
            end
            else if (run_cmd)
            begin
                col_reg        <= col_next;
                row_reg        <= row_next;
                out_valid_reg  <= res_valid;
                pend_clear_reg <= extra_clear;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit_pend)
        begin
            act_reg   <= acce_pkg::ACT_CLEAR;
            glyph_reg <= 8'd0;
            ocol_reg  <= 8'd0;
            orow_reg  <= 8'd0;
            last_reg  <= 1'b1;
        end
        else if (run_cmd)
        begin
            act_reg   <= res_act;
            glyph_reg <= res_glyph;
            ocol_reg  <= res_col;
            orow_reg  <= res_row;
            last_reg  <= !extra_clear;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_action = act_reg;
    assign out_glyph  = glyph_reg;
    assign out_col    = ocol_reg;
    assign out_row    = orow_reg;
    assign out_last   = last_reg;

`ifndef ASSERT_OFF
    // a pending clear always sits behind a draw that is not the last beat
    a_pend_behind_draw: assert property (@(posedge clk) disable iff (!rst_n)
        pend_clear_reg |-> (out_valid_reg && !last_reg && (act_reg == acce_pkg::ACT_DRAW)))
        else $error("pending clear without a leading draw beat");

    // no command is taken from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty command queue");

    // the pending clear goes out next, as the last beat of its byte
    a_pend_then_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_clear_reg && out_ready) |=>
            (out_valid_reg && last_reg && (act_reg == acce_pkg::ACT_CLEAR)))
        else $error("pending clear not delivered next");

    // a clear beat, apart from the cases excluded below, carries the home cell 0, 0
    a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (act_reg == acce_pkg::ACT_CLEAR) && !pend_clear_reg
         && !$past(run_cmd && (head_cmd.op == acce_pkg::OP_SETPOS)))
        |-> (ocol_reg == 8'd0 && orow_reg == 8'd0))
        else $error("clear beat carries a nonzero cell");
`endif

endmodule

/* verif/ansi_csi_console_cursor_engine_unit_tb.sv */
// self-checking testbench for the console cursor engine: byte stimulus, predictor, result checks
module ansi_csi_console_cursor_engine_unit_tb;

    import acce_pkg::*;

    // parser states of the predictor
    typedef enum logic [1:0] {
        PS_NORMAL,
        PS_ESCAPE,
        PS_CSI
    } parse_state_t;

    // one result beat as seen on m_
    typedef struct packed {
        logic       action;
        logic [7:0] glyph;
        logic [7:0] col;
        logic [7:0] row;
        logic       last;
    } cell_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // byte_value
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // glyph, cell_column, cell_row
    logic        m_tuser;   // action
    logic        m_tlast;

    // console bytes waiting to be sent and results waiting to arrive
    logic [7:0]   console_bytes[$];
    cell_result_t expected_cells[$];
    cell_result_t step_results[$];
    cell_result_t want;
    int           bytes_queued;
    int           errors;

    // predictor state
    int           scr_cols;
    int           scr_rows;
    parse_state_t pstate;
    int           seq_params[PARAM_SLOTS];
    int           nparams;
    int           acc;
    logic         have_digits;
    int           cur_col;
    int           cur_row;

    // handshake bookkeeping
    logic beat_in_taken;
    logic idle_on;
    int   in_gap;
    int   out_stall;

    ansi_csi_console_cursor_engine_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // predictor: result bookkeeping
    function automatic void add_result(logic act, int g, int c, int r);
        cell_result_t e;
        e.action = act;
        e.glyph  = g[7:0];
        e.col    = c[7:0];
        e.row    = r[7:0];
        e.last   = 1'b0;
        step_results.push_back(e);
    endfunction

    function automatic void home_and_clear();
        cur_col = 0;
        cur_row = 0;
        add_result(ACT_CLEAR, 0, 0, 0);
    endfunction

    function automatic void reset_sequence();
        pstate      = PS_NORMAL;
        nparams     = 0;
        acc         = 0;
        have_digits = 1'b0;
        for (int i = 0; i < PARAM_SLOTS; i++)
            seq_params[i] = 0;
    endfunction

    // predictor: a byte printed as a character
    function automatic void print_byte(int c);
        if (c == int'(CODE_LF))
        begin
            cur_col = 0;
            cur_row = (cur_row + 1) & 255;
            if (cur_row + 1 >= scr_rows)
                home_and_clear();
        end
        else if (c == int'(CODE_CR))
        begin
            cur_col = 0;
        end
        else if (c == int'(CODE_BS))
        begin
            if (cur_col >= 1)
                cur_col = cur_col - 1;
            add_result(ACT_DRAW, int'(CODE_SPACE), cur_col, cur_row);
        end
        else
        begin
            add_result(ACT_DRAW, c, cur_col, cur_row);
            cur_col = (cur_col + 1) & 255;
            if (cur_col + 1 >= scr_cols)
            begin
                cur_col = 0;
                cur_row = (cur_row + 1) & 255;
            end
            if (cur_row + 1 >= scr_rows)
                home_and_clear();
        end
    endfunction

    // predictor: a byte inside a control sequence
    function automatic void sequence_byte(int c);
        int prow;
        int pcol;
        int mode;
        if (c >= int'(CODE_ZERO) && c <= int'(CODE_NINE))
        begin
            acc = acc * 10 + (c - int'(CODE_ZERO));
            if (acc > int'(PARAM_MAX))
                acc = int'(PARAM_MAX);
            have_digits = 1'b1;
        end
        else if (c == int'(CODE_SEMI))
        begin
            if (nparams < PARAM_SLOTS)
            begin
                seq_params[nparams] = have_digits ? acc : 0;
                nparams++;
            end
            acc         = 0;
            have_digits = 1'b0;
        end
        else
        begin
            if (have_digits && nparams < PARAM_SLOTS)
            begin
                seq_params[nparams] = acc;
                nparams++;
            end
            if (c == int'(CODE_H) || c == int'(CODE_F))
            begin
                prow = 1;
                pcol = 1;
                if (nparams >= 1 && seq_params[0] != 0)
                    prow = seq_params[0];
                if (nparams >= 2 && seq_params[1] != 0)
                    pcol = seq_params[1];
                if (prow > scr_rows)
                    prow = scr_rows;
                if (pcol > scr_cols)
                    pcol = scr_cols;
                if (prow < 1)
                    prow = 1;
                if (pcol < 1)
                    pcol = 1;
                cur_row = prow - 1;
                cur_col = pcol - 1;
            end
            else if (c == int'(CODE_J))
            begin
                mode = (nparams >= 1) ? seq_params[0] : 0;
                if (mode == int'(ERASE_BELOW) || mode == int'(ERASE_ALL))
                    home_and_clear();
            end
            reset_sequence();
        end
    endfunction

    // predictor: one accepted console byte, results appended to the expected store
    function automatic void console_step(logic [7:0] b);
        int c;
        c = int'(b);
        step_results.delete();
        case (pstate)
            PS_NORMAL:
            begin
                if (b == CODE_ESC)
                    pstate = PS_ESCAPE;
                else
                    print_byte(c);
            end
            PS_ESCAPE:
            begin
                if (b == CODE_LBRK)
                begin
                    reset_sequence();
                    pstate = PS_CSI;
                end
                else
                begin
                    print_byte(c);
                    reset_sequence();
                end
            end
            default:
                sequence_byte(c);
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            expected_cells.push_back(step_results[i]);
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endfunction

    // monitor: predict on accepted input beats, check accepted result beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                console_step(s_tdata);
                beat_in_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_cells.size() == 0)
                begin
                    $display("%0t: unexpected result beat, action %0d glyph %0d col %0d row %0d",
                             $time, m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
                    errors++;
                end
                else
                begin
                    want = expected_cells.pop_front();
                    check_field("action", want.action, m_tuser);
                    check_field("glyph", want.glyph, m_tdata[7:0]);
                    check_field("cell_column", want.col, m_tdata[15:8]);
                    check_field("cell_row", want.row, m_tdata[23:16]);
                    check_field("last", want.last, m_tlast);
                end
            end
        end
    end

    // driver: next byte from the queue, with random gap bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || beat_in_taken)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (console_bytes.size() > 0)
                begin
                    s_tdata  <= console_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 3);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            beat_in_taken = 1'b0;
        end
    end

    // receiver: random stall bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_stall > 0)
            begin
                out_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    out_stall = $urandom_range(1, 3);
            end
        end
    end

    task automatic push_byte(input int b);
        console_bytes.push_back(b[7:0]);
        bytes_queued++;
    endtask

    task automatic push_decimal(input int v);
        if (v >= 100)
            push_byte(int'(CODE_ZERO) + v / 100);
        if (v >= 10)
            push_byte(int'(CODE_ZERO) + (v / 10) % 10);
        push_byte(int'(CODE_ZERO) + v % 10);
    endtask

    // one numeric parameter: empty, small, in range, or a long digit run
    task automatic push_param();
        case ($urandom_range(0, 4))
            0: ;
            1: push_decimal($urandom_range(0, 3));
            2: push_decimal($urandom_range(0, 40));
            3: push_decimal($urandom_range(0, 255));
            default:
                repeat ($urandom_range(1, 5))
                    push_byte(int'(CODE_ZERO) + $urandom_range(0, 9));
        endcase
    endtask

    // random stream: plain bytes, cursor controls, sequences, and broken ones
    task automatic queue_random_bytes(input int count);
        int goal;
        int pick;
        int nargs;
        int fin;
        goal = bytes_queued + count;
        while (bytes_queued < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                push_byte($urandom_range(0, 255));
            end
            else if (pick < 50)
            begin
                case ($urandom_range(0, 2))
                    0: push_byte(int'(CODE_LF));
                    1: push_byte(int'(CODE_CR));
                    default: push_byte(int'(CODE_BS));
                endcase
            end
            else if (pick < 85)
            begin
                push_byte(int'(CODE_ESC));
                push_byte(int'(CODE_LBRK));
                nargs = $urandom_range(0, 5);
                for (int k = 0; k < nargs; k++)
                begin
                    if (k > 0)
                        push_byte(int'(CODE_SEMI));
                    push_param();
                end
                case ($urandom_range(0, 5))
                    0, 1: push_byte(int'(CODE_H));
                    2: push_byte(int'(CODE_F));
                    3, 4: push_byte(int'(CODE_J));
                    default:
                    begin
                        fin = int'(CODE_SEMI);
                        while (fin == int'(CODE_SEMI) ||
                               (fin >= int'(CODE_ZERO) && fin <= int'(CODE_NINE)))
                            fin = $urandom_range(0, 255);
                        push_byte(fin);
                    end
                endcase
            end
            else if (pick < 93)
            begin
                push_byte(int'(CODE_ESC));
                push_byte($urandom_range(0, 255));
            end
            else
            begin
                push_byte(int'(CODE_ESC));
                push_byte(int'(CODE_LBRK));
                repeat ($urandom_range(1, 3))
                    push_byte($urandom_range(0, 255));
            end
        end
    endtask

    // wait until every byte is sent and every result has arrived, then let the block settle
    task automatic drain();
        while (console_bytes.size() != 0 || s_tvalid || expected_cells.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_COLS)
            scr_cols = int'(val);
        else
            scr_rows = int'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_screen(input int cols, input int rows);
        write_reg(REG_COLS, cols[7:0]);
        write_reg(REG_ROWS, rows[7:0]);
    endtask

    // stimulus phases
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_COLS;
        cfg_data      = 8'd0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'd0;
        m_tready      = 1'b0;
        beat_in_taken = 1'b0;
        idle_on       = 1'b1;
        in_gap        = 0;
        out_stall     = 0;
        bytes_queued  = 0;
        errors        = 0;
        scr_cols      = int'(COLS_RESET);
        scr_rows      = int'(ROWS_RESET);
        cur_col       = 0;
        cur_row       = 0;
        reset_sequence();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, cursor controls, escape fallbacks
        push_byte(8'h41);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h7F);
        push_byte(int'(CODE_BS));
        push_byte(int'(CODE_BS));
        push_byte(int'(CODE_CR));
        push_byte(int'(CODE_LF));
        push_byte(int'(CODE_ESC));
        push_byte(8'h78);
        push_byte(int'(CODE_ESC));
        push_byte(int'(CODE_ESC));
        // saturating row, zero column, clamped to the bottom row
        push_byte(int'(CODE_ESC));
        push_byte(int'(CODE_LBRK));
        push_decimal(999);
        push_byte(int'(CODE_SEMI));
        push_byte(int'(CODE_ZERO));
        push_byte(int'(CODE_F));
        // draw on the bottom row, then clear
        push_byte(8'h42);
        // erase-all sequence
        push_byte(int'(CODE_ESC));
        push_byte(int'(CODE_LBRK));
        push_decimal(2);
        push_byte(int'(CODE_J));
        drain();

        // random phases over several screen sizes
        queue_random_bytes(250);
        drain();
        set_screen(2, 2);
        queue_random_bytes(150);
        drain();
        set_screen(255, 255);
        queue_random_bytes(250);
        drain();
        set_screen(255, 2);
        queue_random_bytes(120);
        drain();
        set_screen(2, 255);
        queue_random_bytes(120);
        drain();
        set_screen($urandom_range(2, 255), $urandom_range(2, 40));
        queue_random_bytes(120);
        drain();

        // closing stretch without idling
        idle_on = 1'b0;
        set_screen($urandom_range(2, 60), $urandom_range(2, 12));
        queue_random_bytes(220);
        drain();

        if (errors == 0)
            $display("ansi_csi_console_cursor_engine_unit_tb OK");
        else
            $display("ansi_csi_console_cursor_engine_unit_tb NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("ansi_csi_console_cursor_engine_unit_tb NOT OK");
        $finish;
    end

endmodule
